>>> rtl/mwe_pkg.sv
package mwe_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CmdW-1:0] CMD_COUNTER = 2'd0;
  localparam logic [CmdW-1:0] CMD_PINS    = 2'd1;
  localparam logic [CmdW-1:0] CMD_POLL    = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_CHIP_KIND = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BYTE_WIDE = 1'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_EDGE,
    OP_POLL
  } op_kind_e;

  typedef struct packed {
    op_kind_e kind;
    logic     cs;
    logic     di;
    logic     drive;
  } op_t;

endpackage

>>> rtl/mwe_ram.sv
module mwe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mwe_front.sv
module mwe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mwe_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [mwe_pkg::CmdW-1:0]     s_axis_tuser_i,
  input  logic                         clearing_i,
  input  logic                         push_ready_i,
  output logic                         push_valid_o,
  output mwe_pkg::op_t                 push_op_o
);
  import mwe_pkg::*;

  logic       last_clock_q, last_clock_d;
  logic       din_drive_q, din_drive_d;
  logic       din_level_q, din_level_d;
  logic       accept;
  logic [7:0] counter_value;
  logic [7:0] pin_direction;
  logic [7:0] pin_data;

  assign counter_value = s_axis_tdata_i[7:0];
  assign pin_direction = s_axis_tdata_i[15:8];
  assign pin_data      = s_axis_tdata_i[23:16];

  assign s_axis_tready_o = push_ready_i && !clearing_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_valid_o    = accept;

  always_comb begin
    last_clock_d    = last_clock_q;
    din_drive_d     = din_drive_q;
    din_level_d     = din_level_q;
    push_op_o.kind  = OP_NONE;
    push_op_o.cs    = counter_value[7];
    push_op_o.di    = din_drive_q && din_level_q;
    push_op_o.drive = din_drive_q;
    case (s_axis_tuser_i)
      CMD_COUNTER: begin
        last_clock_d = counter_value[1];
        if (counter_value[1] && !last_clock_q) begin
          push_op_o.kind = OP_EDGE;
        end
      end
      CMD_PINS: begin
        din_drive_d = pin_direction[4];
        din_level_d = pin_data[4];
      end
      CMD_POLL: begin
        push_op_o.kind = OP_POLL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clock_q <= 1'b0;
      din_drive_q  <= 1'b0;
      din_level_q  <= 1'b0;
    end else if (accept) begin
      last_clock_q <= last_clock_d;
      din_drive_q  <= din_drive_d;
      din_level_q  <= din_level_d;
    end
  end

endmodule

>>> rtl/mwe_fifo.sv
module mwe_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mwe_pkg::op_t push_op_i,
  output logic         push_ready_o,
  input  logic         pop_i,
  output logic         pop_valid_o,
  output mwe_pkg::op_t pop_op_o
);
  import mwe_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  op_t             slot_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = count_q != CntW'(FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_op_o     = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mwe_back.sv
module mwe_back #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mwe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mwe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         op_valid_i,
  input  mwe_pkg::op_t                 op_i,
  output logic                         op_pop_o,
  output logic                         clearing_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mwe_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import mwe_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BUSY,
    PH_DATA,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_WRITE
  } act_e;

  function automatic logic [3:0] kind_cmd(input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd1:       r = 4'd10;
      3'd2, 3'd3: r = 4'd12;
      3'd4, 3'd5: r = 4'd14;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kind_addr(input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd1:       r = 4'd7;
      3'd2, 3'd3: r = 4'd9;
      3'd4, 3'd5: r = 4'd11;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] kind_mask(input logic [2:0] k);
    logic [10:0] r;
    case (k)
      3'd1:    r = 11'h07F;
      3'd2:    r = 11'h0FF;
      3'd3:    r = 11'h1FF;
      3'd4:    r = 11'h3FF;
      3'd5:    r = 11'h7FF;
      default: r = 11'h000;
    endcase
    return r;
  endfunction

  // The word index never exceeds eleven bits, so five compare-and-subtract
  // steps bring it below the store depth.
  function automatic logic [AW-1:0] wrap_index(input logic [10:0] a);
    logic [10:0] r;
    r = a;
    for (int k = 4; k >= 0; k--) begin
      if (32'(r) >= (MEM_WORDS << k)) begin
        r = 11'(32'(r) - (MEM_WORDS << k));
      end
    end
    return r[AW-1:0];
  endfunction

  logic [2:0]    chip_kind_q;
  logic          byte_wide_q;
  phase_e        phase_q, phase_d;
  logic [16:0]   shift_in_q, shift_in_d;
  logic [3:0]    bits_left_q, bits_left_d;
  logic [10:0]   cell_address_q, cell_address_d;
  logic [15:0]   shift_out_q, shift_out_d;
  logic          write_locked_q, write_locked_d;
  logic [1:0]    busy_ticks_q, busy_ticks_d;
  logic          out_level_q, out_level_d;
  logic          mem_q;
  act_e          act_q, act_d;
  logic [AW-1:0] word_q, word_d;
  logic          hi_q, hi_d;
  logic [15:0]   wval_q, wval_d;
  logic          clear_q;
  logic [AW-1:0] clear_cnt_q;
  logic          m_valid_q;
  logic          m_level_q;

  logic          out_free;
  logic          pop;
  logic [3:0]    abits;
  logic [3:0]    kc;
  logic [10:0]   amask;
  logic [16:0]   opc;
  logic [16:0]   sub;
  logic [10:0]   widx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;
  logic [15:0]   load_val;

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign pop        = op_valid_i && !mem_q && !clear_q && out_free;
  assign op_pop_o   = pop;
  assign clearing_o = clear_q;

  assign kc    = kind_cmd(chip_kind_q);
  assign abits = kind_addr(chip_kind_q) - (byte_wide_q ? 4'd0 : 4'd1);
  assign amask = byte_wide_q ? kind_mask(chip_kind_q) : (kind_mask(chip_kind_q) >> 1);

  always_comb begin
    phase_d        = phase_q;
    shift_in_d     = shift_in_q;
    bits_left_d    = bits_left_q;
    cell_address_d = cell_address_q;
    shift_out_d    = shift_out_q;
    write_locked_d = write_locked_q;
    busy_ticks_d   = busy_ticks_q;
    out_level_d    = out_level_q;
    act_d          = ACT_NONE;
    hi_d           = 1'b0;
    wval_d         = 16'hFFFF;
    opc            = '0;
    sub            = '0;
    case (op_i.kind)
      OP_EDGE: begin
        out_level_d = byte_wide_q ? shift_out_q[7] : shift_out_q[15];
        shift_out_d = {shift_out_q[14:0], 1'b0};
        if (!op_i.cs) begin
          phase_d = PH_IDLE;
        end
        case (phase_d)
          PH_IDLE: begin
            shift_in_d = '0;
            if (op_i.cs) begin
              if (op_i.di) begin
                out_level_d = 1'b0;
                phase_d     = PH_START;
                bits_left_d = (kc == 4'd0) ? 4'd0 : kc - (byte_wide_q ? 4'd1 : 4'd2);
              end else if (!op_i.drive) begin
                phase_d      = PH_BUSY;
                shift_out_d  = '0;
                out_level_d  = 1'b0;
                busy_ticks_d = '0;
              end
            end
          end
          PH_START: begin
            shift_in_d = {shift_in_q[15:0], op_i.di};
            if (kc != 4'd0) begin
              bits_left_d = bits_left_q - 4'd1;
              if (bits_left_d == 4'd0) begin
                opc            = shift_in_d >> abits;
                sub            = shift_in_d >> (abits - 4'd2);
                phase_d        = PH_IDLE;
                cell_address_d = shift_in_d[10:0] & amask;
                if (opc == 17'd3) begin
                  if (!write_locked_q) begin
                    act_d  = ACT_WRITE;
                    wval_d = 16'hFFFF;
                  end
                end else if (opc == 17'd2) begin
                  act_d       = ACT_LOAD;
                  out_level_d = 1'b0;
                  phase_d     = PH_WAIT;
                end else if (opc == 17'd1) begin
                  shift_in_d = 17'd1;
                  phase_d    = PH_DATA;
                end else if (opc == 17'd0) begin
                  if (sub == 17'd0) begin
                    write_locked_d = 1'b1;
                  end else if (sub == 17'd3) begin
                    write_locked_d = 1'b0;
                  end
                end
              end
            end
          end
          PH_DATA: begin
            shift_in_d = {shift_in_q[15:0], op_i.di};
            if (byte_wide_q ? shift_in_d[8] : shift_in_d[16]) begin
              if (!write_locked_q) begin
                act_d  = ACT_WRITE;
                wval_d = shift_in_d[15:0];
              end
              busy_ticks_d = '0;
              shift_out_d  = '0;
              out_level_d  = 1'b0;
              phase_d      = PH_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      OP_POLL: begin
        if (phase_q == PH_BUSY || phase_q == PH_IDLE) begin
          if (busy_ticks_q < 2'd2) begin
            busy_ticks_d = busy_ticks_q + 2'd1;
            shift_out_d  = '0;
            out_level_d  = 1'b0;
          end else begin
            shift_out_d = 16'hFFFF;
            out_level_d = 1'b1;
            phase_d     = PH_WAIT;
          end
        end
      end
      default: begin
      end
    endcase
    widx   = byte_wide_q ? {1'b0, cell_address_d[10:1]} : cell_address_d;
    word_d = wrap_index(widx);
    hi_d   = byte_wide_q && cell_address_d[0];
  end

  assign load_val = !byte_wide_q ? ram_rdata :
                    hi_q ? {8'h00, ram_rdata[15:8]} : {8'h00, ram_rdata[7:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = wval_q;
    if (clear_q) begin
      ram_we    = 1'b1;
      ram_waddr = clear_cnt_q;
      ram_wdata = 16'hFFFF;
    end else if (mem_q && act_q == ACT_WRITE) begin
      ram_we = 1'b1;
      if (byte_wide_q) begin
        ram_wdata = hi_q ? {wval_q[7:0], ram_rdata[7:0]} : {ram_rdata[15:8], wval_q[7:0]};
      end
    end
  end

  mwe_ram #(
    .WIDTH(16),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(word_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_kind_q    <= '0;
      byte_wide_q    <= 1'b0;
      phase_q        <= PH_IDLE;
      shift_in_q     <= '0;
      bits_left_q    <= '0;
      cell_address_q <= '0;
      shift_out_q    <= '0;
      write_locked_q <= 1'b1;
      busy_ticks_q   <= '0;
      out_level_q    <= 1'b0;
      mem_q          <= 1'b0;
      act_q          <= ACT_NONE;
      word_q         <= '0;
      hi_q           <= 1'b0;
      wval_q         <= '0;
      clear_q        <= 1'b1;
      clear_cnt_q    <= '0;
      m_valid_q      <= 1'b0;
      m_level_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CHIP_KIND: chip_kind_q <= cfg_data_i;
          REG_BYTE_WIDE: byte_wide_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (clear_q) begin
        clear_cnt_q <= clear_cnt_q + 1'b1;
        if (clear_cnt_q == AW'(MEM_WORDS - 1)) begin
          clear_q <= 1'b0;
        end
      end
      if (pop) begin
        phase_q        <= phase_d;
        shift_in_q     <= shift_in_d;
        bits_left_q    <= bits_left_d;
        cell_address_q <= cell_address_d;
        shift_out_q    <= shift_out_d;
        write_locked_q <= write_locked_d;
        busy_ticks_q   <= busy_ticks_d;
        out_level_q    <= out_level_d;
        act_q          <= act_d;
        word_q         <= word_d;
        hi_q           <= hi_d;
        wval_q         <= wval_d;
        mem_q          <= act_d != ACT_NONE;
        m_valid_q      <= 1'b1;
        m_level_q      <= out_level_d;
      end else begin
        mem_q <= 1'b0;
        if (mem_q && act_q == ACT_LOAD) begin
          shift_out_q <= load_val;
        end
        if (m_axis_tready_i) begin
          m_valid_q <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - 1){1'b0}}, m_level_q};

endmodule

>>> rtl/microwire_eeprom_slave.sv
// Three-wire serial EEPROM of the 93Cx6 family, driven by counter writes, pin
// writes and busy polls, one event per input transfer and one result transfer
// carrying the data-out level per event. Events that touch no store word do not
// hold off the next one; a read, or a write or erase that reaches the store,
// does, while the store is read and then written or unloaded. A two-entry queue
// sits between the event decoder and the executing unit, and the result is held
// in an output register, so input transfers continue while a result waits until
// the queue is full. After reset every store word is filled with ones, and no
// input transfer is taken until that is done; configuration writes are taken at
// any time.
module microwire_eeprom_slave #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mwe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mwe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: counter_value[7:0], pin_direction[15:8], pin_data[23:16].
  input  logic [mwe_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: cmd[1:0].
  input  logic [mwe_pkg::CmdW-1:0]     s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0: serial_out[0], zero fill above.
  output logic [mwe_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import mwe_pkg::*;

  logic clearing;
  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop;
  logic pop_valid;
  op_t  pop_op;

  mwe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .clearing_i     (clearing),
    .push_ready_i   (push_ready),
    .push_valid_o   (push_valid),
    .push_op_o      (push_op)
  );

  mwe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_op_i   (push_op),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_op_o    (pop_op)
  );

  mwe_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_valid_i     (pop_valid),
    .op_i           (pop_op),
    .op_pop_o       (pop),
    .clearing_o     (clearing),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule
